/* rtl/pcbn_pkg.sv */
// shared constants and types for the per-class box suppression block
`timescale 1ns / 1ps
package pcbn_pkg;

    localparam int SCORE_W         = 17;
    localparam int CLASS_W         = 4;
    localparam int DEF_MAX_BOXES   = 64;
    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_COORD_BITS  = 16;
    localparam int PIPE_DEPTH      = 4;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OVL_THR   = 2'd1;

    localparam logic [SCORE_W-1:0] THR_RESET = 17'd32768;

    typedef struct packed {
        logic load;
        logic shift;
    } t_ctl;

endpackage

/* rtl/per_class_box_nms_unit.sv */
// top level: box ring of sorted cells, overlap pipeline, result register
// load: one candidate per cycle while loading; if stored, sorted in on transfer
// suppression: (K+1) passes, K = kept boxes; each
//   pass rotates the ring once through the four-stage overlap pipeline
// a result waits in a pending register until the next keep or the end of run
// synchronous active-low reset empties the ring and restores both thresholds
`timescale 1ns / 1ps
module per_class_box_nms_unit #(
    parameter int MAX_BOXES   = pcbn_pkg::DEF_MAX_BOXES,
    parameter int MAX_CLASSES = pcbn_pkg::DEF_MAX_CLASSES,
    parameter int COORD_BITS  = pcbn_pkg::DEF_COORD_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // center_x, center_y, box_width, box_height, score, object_class
    input  logic [((4*COORD_BITS+21+7)/8)*8-1:0]   s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // out_center_x, out_center_y, out_width, out_height, out_score, out_class
    output logic [((4*COORD_BITS+21+7)/8)*8-1:0]   m_axis_tdata,
    // no_boxes
    output logic                                   m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pcbn_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcbn_pkg::SCORE_W-1:0]           i_cfg_data
);

    localparam int CB      = COORD_BITS;
    localparam int BOX_W   = 4*CB + 22;
    localparam int PAY_W   = 4*CB + 21;
    localparam int SC_LO   = 4*CB;
    localparam int CL_LO   = 4*CB + pcbn_pkg::SCORE_W;
    localparam int V_BIT   = 4*CB + 21;
    localparam int TDATA_W = ((PAY_W + 7) / 8) * 8;
    localparam int CW      = $clog2(MAX_BOXES + 1);
    localparam int RING    = MAX_BOXES + pcbn_pkg::PIPE_DEPTH;
    localparam int RW      = $clog2(RING);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                    r_state;
    logic [CW-1:0]                 r_count;
    logic [RW-1:0]                 r_pass_cnt;
    logic [pcbn_pkg::SCORE_W-1:0]  r_sthr, r_othr;
    logic [4*CB-1:0]               r_ref_geom;
    logic [pcbn_pkg::CLASS_W-1:0]  r_ref_cls;
    logic                          r_ref_v;
    logic [BOX_W-1:0]              r_pend;
    logic                          r_out_v;
    logic [TDATA_W-1:0]            r_out_data;
    logic                          r_out_user;
    logic                          r_out_last;

    logic [BOX_W-1:0]              w_box [MAX_BOXES];
    logic                          w_before [MAX_BOXES];
    logic [BOX_W-1:0]              w_new;
    logic [BOX_W-1:0]              w_head;
    logic [BOX_W-1:0]              w_pipe_in;
    logic [BOX_W-1:0]              w_pipe_out;
    logic                          w_acc, w_store, w_cand, w_out_free, w_en, w_take, w_cmp;
    logic                          w_out_load;
    pcbn_pkg::t_ctl                w_ctl;

    assign w_new  = {1'b1, s_axis_tdata[PAY_W-1:0]};
    assign w_head = w_box[0];

    assign s_axis_tready = (r_state == ST_LOAD);
    assign o_cfg_ready   = 1'b1;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_store = w_acc
        && (w_new[SC_LO +: pcbn_pkg::SCORE_W] > r_sthr)
        && (32'(w_new[CL_LO +: pcbn_pkg::CLASS_W]) < MAX_CLASSES)
        && (r_count < CW'(MAX_BOXES));

    assign w_cand     = (r_state == ST_PASS) && w_head[V_BIT] && !r_ref_v;
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_en       = !(w_cand && r_pend[V_BIT] && !w_out_free);
    assign w_take     = w_cand && w_en;
    assign w_cmp      = r_ref_v && w_head[V_BIT]
                        && (w_head[CL_LO +: pcbn_pkg::CLASS_W] == r_ref_cls);
    assign w_out_load = (w_take && r_pend[V_BIT]) || ((r_state == ST_FIN) && w_out_free);

    always_comb begin
        w_pipe_in = w_head;
        if (w_take) begin
            w_pipe_in[V_BIT] = 1'b0;
        end
    end

    assign w_ctl.load  = w_store;
    assign w_ctl.shift = (r_state == ST_PASS) && w_en;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_BOXES; gi++) begin : g_cell
            pcbn_cell #(
                .COORD_BITS (COORD_BITS)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_new         (w_new),
                .i_left        ((gi == 0) ? '0 : w_box[(gi == 0) ? 0 : gi-1]),
                .i_left_before ((gi == 0) ? 1'b0 : w_before[(gi == 0) ? 0 : gi-1]),
                .i_right       ((gi == MAX_BOXES-1) ? w_pipe_out
                                : w_box[(gi == MAX_BOXES-1) ? gi : gi+1]),
                .o_box         (w_box[gi]),
                .o_before      (w_before[gi])
            );
        end
    endgenerate

    pcbn_iou #(
        .COORD_BITS (COORD_BITS)
    ) u_iou (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_ctl.shift),
        .i_box      (w_pipe_in),
        .i_cmp      (w_cmp),
        .i_ref_geom (r_ref_geom),
        .i_thr      (r_othr),
        .o_box      (w_pipe_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_count      <= '0;
            r_pass_cnt   <= '0;
            r_sthr       <= pcbn_pkg::THR_RESET;
            r_othr       <= pcbn_pkg::THR_RESET;
            r_ref_v      <= 1'b0;
            r_pend[V_BIT] <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    pcbn_pkg::REG_SCORE_THR: r_sthr <= i_cfg_data;
                    pcbn_pkg::REG_OVL_THR:   r_othr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_acc && s_axis_tlast) begin
                        r_state    <= ST_PASS;
                        r_pass_cnt <= '0;
                        r_count    <= '0;
                    end else if (w_store) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                ST_PASS: begin
                    if (w_en) begin
                        if (w_take) begin
                            r_ref_geom <= w_head[4*CB-1:0];
                            r_ref_cls  <= w_head[CL_LO +: pcbn_pkg::CLASS_W];
                            r_pend     <= w_head;
                            if (r_pend[V_BIT]) begin
                                r_out_data <= TDATA_W'(r_pend[PAY_W-1:0]);
                                r_out_user <= 1'b0;
                                r_out_last <= 1'b0;
                            end
                        end
                        if (r_pass_cnt == RW'(RING - 1)) begin
                            r_pass_cnt <= '0;
                            r_ref_v    <= 1'b0;
                            if (!r_ref_v) begin
                                r_state <= ST_FIN;
                            end
                        end else begin
                            r_pass_cnt <= r_pass_cnt + 1'b1;
                            if (w_take) begin
                                r_ref_v <= 1'b1;
                            end
                        end
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_data    <= r_pend[V_BIT] ? TDATA_W'(r_pend[PAY_W-1:0]) : '0;
                        r_out_user    <= !r_pend[V_BIT];
                        r_out_last    <= 1'b1;
                        r_pend[V_BIT] <= 1'b0;
                        r_state       <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    a_pipe_empty_at_pass_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS && r_pass_cnt == '0) |-> !w_pipe_out[V_BIT])
        else $error("overlap pipeline holds a box at a pass boundary");

    a_ring_empty_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> !w_box[0][V_BIT])
        else $error("box left in ring when suppression finished");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES))
        else $error("stored count beyond capacity");

    a_out_held_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("result changed while waiting for transfer");

    a_no_input_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PASS) |-> !w_ctl.load)
        else $error("ring insert during suppression");

endmodule

/* rtl/pcbn_cell.sv */
// one slot of the box ring: sorted insert while loading, shift while suppressing
`timescale 1ns / 1ps
module pcbn_cell #(
    parameter int COORD_BITS = pcbn_pkg::DEF_COORD_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcbn_pkg::t_ctl            i_ctl,
    input  logic [4*COORD_BITS+21:0]  i_new,
    input  logic [4*COORD_BITS+21:0]  i_left,
    input  logic                      i_left_before,
    input  logic [4*COORD_BITS+21:0]  i_right,
    output logic [4*COORD_BITS+21:0]  o_box,
    output logic                      o_before
);

    localparam int SC_LO = 4*COORD_BITS;
    localparam int CL_LO = 4*COORD_BITS + pcbn_pkg::SCORE_W;
    localparam int V_BIT = 4*COORD_BITS + 21;

    logic [4*COORD_BITS+21:0] r_box;
    logic [4*COORD_BITS+21:0] n_box;
    logic [pcbn_pkg::CLASS_W-1:0] w_my_cls;
    logic [pcbn_pkg::CLASS_W-1:0] w_new_cls;
    logic [pcbn_pkg::SCORE_W-1:0] w_my_sc;
    logic [pcbn_pkg::SCORE_W-1:0] w_new_sc;

    assign w_my_cls  = r_box[CL_LO +: pcbn_pkg::CLASS_W];
    assign w_new_cls = i_new[CL_LO +: pcbn_pkg::CLASS_W];
    assign w_my_sc   = r_box[SC_LO +: pcbn_pkg::SCORE_W];
    assign w_new_sc  = i_new[SC_LO +: pcbn_pkg::SCORE_W];

    // new item ranks ahead of this slot
    assign o_before = !r_box[V_BIT] || (w_new_cls < w_my_cls) ||
                      ((w_new_cls == w_my_cls) && (w_new_sc > w_my_sc));

    always_comb begin
        n_box = r_box;
        if (i_ctl.shift) begin
            n_box = i_right;
        end else if (i_ctl.load) begin
            if (i_left_before) begin
                n_box = i_left;
            end else if (o_before) begin
                n_box = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= '0;
        end else begin
            r_box <= n_box;
        end
    end

    assign o_box = r_box;

endmodule

/* rtl/pcbn_iou.sv */
// pipelined overlap test of a passing box against the reference box
`timescale 1ns / 1ps
module pcbn_iou #(
    parameter int COORD_BITS = pcbn_pkg::DEF_COORD_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [4*COORD_BITS+21:0]           i_box,
    input  logic                               i_cmp,
    input  logic [4*COORD_BITS-1:0]            i_ref_geom,
    input  logic [pcbn_pkg::SCORE_W-1:0]       i_thr,
    output logic [4*COORD_BITS+21:0]           o_box
);

    localparam int CB    = COORD_BITS;
    localparam int BOX_W = 4*CB + 22;
    localparam int V_BIT = 4*CB + 21;
    localparam int EW    = CB + 3;
    localparam int DW    = CB + 2;
    localparam int IW    = 2*CB + 4;
    localparam int AW    = 2*CB;
    localparam int UW    = 2*CB + 3;
    localparam int LOW_W = 18;
    localparam int HI_W  = UW - LOW_W;
    localparam int SW    = pcbn_pkg::SCORE_W;
    localparam int PW    = SW + UW;

    logic signed [EW-1:0] w_la, w_ra, w_ta, w_ba, w_lb, w_rb, w_tb, w_bb;
    logic signed [EW-1:0] w_il, w_ir, w_it, w_ib, w_dxs, w_dys;
    logic [DW-1:0] w_dx, w_dy;

    logic [BOX_W-1:0] r_box1, r_box2, r_box3, r_box4;
    logic             r_cmp1, r_cmp2, r_cmp3, r_cmp4;
    logic [DW-1:0]    r_dx, r_dy;
    logic [CB-1:0]    r_wa, r_ha, r_wb, r_hb;
    logic [IW-1:0]    r_inter2, r_inter3, r_inter4;
    logic [AW-1:0]    r_aa, r_ab;
    logic [UW-1:0]    r_uni;
    logic [SW+LOW_W-1:0] r_plo;
    logic [SW+HI_W-1:0]  r_phi;
    logic [PW-1:0]    w_total;
    logic [PW-1:0]    w_lhs;
    logic             w_sup;

    assign w_la = signed'({2'b00, i_ref_geom[0 +: CB], 1'b0}) - signed'({3'b000, i_ref_geom[2*CB +: CB]});
    assign w_ra = signed'({2'b00, i_ref_geom[0 +: CB], 1'b0}) + signed'({3'b000, i_ref_geom[2*CB +: CB]});
    assign w_ta = signed'({2'b00, i_ref_geom[CB +: CB], 1'b0}) - signed'({3'b000, i_ref_geom[3*CB +: CB]});
    assign w_ba = signed'({2'b00, i_ref_geom[CB +: CB], 1'b0}) + signed'({3'b000, i_ref_geom[3*CB +: CB]});
    assign w_lb = signed'({2'b00, i_box[0 +: CB], 1'b0}) - signed'({3'b000, i_box[2*CB +: CB]});
    assign w_rb = signed'({2'b00, i_box[0 +: CB], 1'b0}) + signed'({3'b000, i_box[2*CB +: CB]});
    assign w_tb = signed'({2'b00, i_box[CB +: CB], 1'b0}) - signed'({3'b000, i_box[3*CB +: CB]});
    assign w_bb = signed'({2'b00, i_box[CB +: CB], 1'b0}) + signed'({3'b000, i_box[3*CB +: CB]});

    assign w_il  = (w_la > w_lb) ? w_la : w_lb;
    assign w_ir  = (w_ra < w_rb) ? w_ra : w_rb;
    assign w_it  = (w_ta > w_tb) ? w_ta : w_tb;
    assign w_ib  = (w_ba < w_bb) ? w_ba : w_bb;
    assign w_dxs = w_ir - w_il;
    assign w_dys = w_ib - w_it;
    assign w_dx  = (w_il > w_ir) ? '0 : w_dxs[DW-1:0];
    assign w_dy  = (w_it > w_ib) ? '0 : w_dys[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box1 <= '0;
            r_box2 <= '0;
            r_box3 <= '0;
            r_box4 <= '0;
            r_cmp1 <= 1'b0;
            r_cmp2 <= 1'b0;
            r_cmp3 <= 1'b0;
            r_cmp4 <= 1'b0;
        end else if (i_en) begin
            r_box1 <= i_box;
            r_box2 <= r_box1;
            r_box3 <= r_box2;
            r_box4 <= r_box3;
            r_cmp1 <= i_cmp;
            r_cmp2 <= r_cmp1;
            r_cmp3 <= r_cmp2;
            r_cmp4 <= r_cmp3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx     <= w_dx;
            r_dy     <= w_dy;
            r_wa     <= i_ref_geom[2*CB +: CB];
            r_ha     <= i_ref_geom[3*CB +: CB];
            r_wb     <= i_box[2*CB +: CB];
            r_hb     <= i_box[3*CB +: CB];
            r_inter2 <= IW'(r_dx * r_dy);
            r_aa     <= AW'(r_wa * r_ha);
            r_ab     <= AW'(r_wb * r_hb);
            r_inter3 <= r_inter2;
            r_uni    <= UW'({r_aa, 2'b00}) + UW'({r_ab, 2'b00}) - UW'(r_inter2);
            r_inter4 <= r_inter3;
            r_plo    <= (SW+LOW_W)'(i_thr * r_uni[LOW_W-1:0]);
            r_phi    <= (SW+HI_W)'(i_thr * r_uni[UW-1:LOW_W]);
        end
    end

    assign w_total = PW'({r_phi, {LOW_W{1'b0}}}) + PW'(r_plo);
    assign w_lhs   = PW'({r_inter4, 16'b0});
    assign w_sup   = r_cmp4 && (w_lhs > w_total);

    always_comb begin
        o_box        = r_box4;
        o_box[V_BIT] = r_box4[V_BIT] && !w_sup;
    end

endmodule

/* tb/sv/per_class_box_nms_unit_checker.sv */
// checker: predicts kept boxes per run and compares the output stream
`timescale 1ns / 1ps
module per_class_box_nms_unit_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [87:0] i_in_data,
    input  logic        i_in_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [87:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [pcbn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pcbn_pkg::SCORE_W-1:0]   i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [15:0]                  cx, cy, w, h;
        logic [pcbn_pkg::SCORE_W-1:0] score;
        logic [pcbn_pkg::CLASS_W-1:0] cls;
        logic                         empty;
        logic                         last;
    } t_kept_box;

    t_kept_box                    kept_q[$];
    logic [pcbn_pkg::SCORE_W-1:0] score_thr;
    logic [pcbn_pkg::SCORE_W-1:0] ovl_thr;
    longint                       box_cx[64], box_cy[64], box_w[64], box_h[64];
    logic [pcbn_pkg::SCORE_W-1:0] box_score[64];
    logic [pcbn_pkg::CLASS_W-1:0] box_cls[64];
    int                           box_count;

    initial o_fail_count = 0;
    assign o_pending = kept_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        o_fail_count++;
    endtask

    function automatic bit iou_above(int a, int b);
        longint la, ra, ta, ba, lb, rb, tb, bb, il, ir, it, ib;
        logic [127:0] inter, uni;
        la = 2 * box_cx[a] - box_w[a];
        ra = 2 * box_cx[a] + box_w[a];
        ta = 2 * box_cy[a] - box_h[a];
        ba = 2 * box_cy[a] + box_h[a];
        lb = 2 * box_cx[b] - box_w[b];
        rb = 2 * box_cx[b] + box_w[b];
        tb = 2 * box_cy[b] - box_h[b];
        bb = 2 * box_cy[b] + box_h[b];
        il = (la > lb) ? la : lb;
        ir = (ra < rb) ? ra : rb;
        it = (ta > tb) ? ta : tb;
        ib = (ba < bb) ? ba : bb;
        if (it > ib || il > ir)
            return 0;
        inter = 128'(ir - il) * 128'(ib - it);
        uni = 128'(4 * box_w[a] * box_h[a]) + 128'(4 * box_w[b] * box_h[b]) - inter;
        return (inter << 16) > (128'(ovl_thr) * uni);
    endfunction

    task automatic suppress_run();
        int        order[64];
        bit        gone[64];
        int        n, pos, a, b, kept;
        t_kept_box kb;
        kept = 0;
        for (int i = 0; i < 64; i++) gone[i] = 0;
        for (int c = 0; c < 16; c++) begin
            n = 0;
            for (int i = 0; i < box_count; i++) begin
                if (box_cls[i] == c) begin
                    pos = n;
                    while (pos > 0 && box_score[order[pos-1]] < box_score[i]) begin
                        order[pos] = order[pos-1];
                        pos--;
                    end
                    order[pos] = i;
                    n++;
                end
            end
            for (int i = 0; i < n; i++) begin
                a = order[i];
                if (gone[a])
                    continue;
                kb.cx = box_cx[a][15:0];
                kb.cy = box_cy[a][15:0];
                kb.w = box_w[a][15:0];
                kb.h = box_h[a][15:0];
                kb.score = box_score[a];
                kb.cls = box_cls[a];
                kb.empty = 0;
                kb.last = 0;
                kept_q.insert(kept_q.size(), kb);
                kept++;
                for (int j = i + 1; j < n; j++) begin
                    b = order[j];
                    if (!gone[b] && iou_above(a, b))
                        gone[b] = 1;
                end
            end
        end
        if (kept == 0) begin
            kb = '{default: 0};
            kb.empty = 1;
            kept_q.insert(kept_q.size(), kb);
        end
        kept_q[kept_q.size()-1].last = 1;
    endtask

    always @(posedge i_clk) begin
        t_kept_box kb;
        if (!i_rst_n) begin
            score_thr <= pcbn_pkg::THR_RESET;
            ovl_thr <= pcbn_pkg::THR_RESET;
            box_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == pcbn_pkg::REG_SCORE_THR)
                    score_thr <= i_cfg_data;
                else if (i_cfg_index == pcbn_pkg::REG_OVL_THR)
                    ovl_thr <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data[80:64] > score_thr && box_count < 64) begin
                    box_cx[box_count] = 64'(i_in_data[15:0]);
                    box_cy[box_count] = 64'(i_in_data[31:16]);
                    box_w[box_count] = 64'(i_in_data[47:32]);
                    box_h[box_count] = 64'(i_in_data[63:48]);
                    box_score[box_count] = i_in_data[80:64];
                    box_cls[box_count] = i_in_data[84:81];
                    box_count++;
                end
                if (i_in_last) begin
                    suppress_run();
                    box_count = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (kept_q.size() == 0) begin
                    report("unexpected result", i_out_data[31:0], 32'd0);
                end else begin
                    kb = kept_q.pop_front();
                    if (i_out_data[15:0] !== kb.cx)
                        report("center_x", 32'(i_out_data[15:0]), 32'(kb.cx));
                    if (i_out_data[31:16] !== kb.cy)
                        report("center_y", 32'(i_out_data[31:16]), 32'(kb.cy));
                    if (i_out_data[47:32] !== kb.w)
                        report("width", 32'(i_out_data[47:32]), 32'(kb.w));
                    if (i_out_data[63:48] !== kb.h)
                        report("height", 32'(i_out_data[63:48]), 32'(kb.h));
                    if (i_out_data[80:64] !== kb.score)
                        report("score", 32'(i_out_data[80:64]), 32'(kb.score));
                    if (i_out_data[84:81] !== kb.cls)
                        report("class", 32'(i_out_data[84:81]), 32'(kb.cls));
                    if (i_out_user !== kb.empty)
                        report("no_boxes", 32'(i_out_user), 32'(kb.empty));
                    if (i_out_last !== kb.last)
                        report("last", 32'(i_out_last), 32'(kb.last));
                end
            end
        end
    end
endmodule

/* tb/sv/per_class_box_nms_unit_test.sv */
// testbench top: stimulus, idle patterns, watchdog and verdict
`timescale 1ns / 1ps
module per_class_box_nms_unit_test;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [pcbn_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [pcbn_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                           i_clk = 0;
    logic                           i_rst_n = 0;
    logic                           s_tvalid = 0;
    logic [87:0]                    s_tdata = '0;
    logic                           s_tlast = 0;
    logic                           m_tready = 0;
    logic                           cfg_valid = 0;
    logic [pcbn_pkg::CFG_IDX_W-1:0] cfg_index = pcbn_pkg::REG_SCORE_THR;
    logic [pcbn_pkg::SCORE_W-1:0]   cfg_data = '0;
    wire                            s_tready, m_tvalid, m_tuser, m_tlast, cfg_ready;
    wire  [87:0]                    m_tdata;
    int                             fail_count, pending;
    int                             send_idle_pct = 0, recv_stall_pct = 0;
    int                             quiet_cycles = 0;
    logic [pcbn_pkg::SCORE_W-1:0]   cur_score_thr = pcbn_pkg::THR_RESET;
    logic [15:0]                    cluster_x, cluster_y;

    always #4 i_clk = ~i_clk;

    per_class_box_nms_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
        .s_axis_tdata(s_tdata), .s_axis_tlast(s_tlast),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
        .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser), .m_axis_tlast(m_tlast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    per_class_box_nms_unit_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_tvalid), .i_in_ready(s_tready), .i_in_data(s_tdata),
        .i_in_last(s_tlast),
        .i_out_valid(m_tvalid), .i_out_ready(m_tready), .i_out_data(m_tdata),
        .i_out_user(m_tuser), .i_out_last(m_tlast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk)
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("per_class_box_nms_unit verification failed");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge of the transfer with tvalid still high
    task automatic send_box(input logic [15:0] cx, cy, w, h,
                            input logic [pcbn_pkg::SCORE_W-1:0] score,
                            input logic [pcbn_pkg::CLASS_W-1:0] cls, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata <= {3'b0, cls, score, h, w, cy, cx};
        s_tlast <= last;
        forever begin
            @(negedge i_clk);
            if (s_tready) begin
                @(posedge i_clk);
                break;
            end
        end
    endtask

    // returns at the edge of the transfer with cfg_valid still high
    task automatic write_reg(input logic [pcbn_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcbn_pkg::SCORE_W-1:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        forever begin
            @(negedge i_clk);
            if (cfg_ready) begin
                @(posedge i_clk);
                break;
            end
        end
        if (idx == pcbn_pkg::REG_SCORE_THR)
            cur_score_thr = val;
    endtask

    task automatic drain();
        s_tvalid <= 0;
        forever begin
            @(negedge i_clk);
            if (pending == 0)
                break;
        end
        repeat (150) @(posedge i_clk);
    endtask

    task automatic random_box(input logic last);
        logic [15:0]                  cx, cy, w, h;
        logic [pcbn_pkg::SCORE_W-1:0] score;
        logic [pcbn_pkg::CLASS_W-1:0] cls;
        if ($urandom_range(0, 5) == 0) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            w = 16'($urandom);
            h = 16'($urandom);
        end else begin
            cx = cluster_x + 16'($urandom_range(0, 120));
            cy = cluster_y + 16'($urandom_range(0, 120));
            w = 16'($urandom_range(16, 800));
            h = 16'($urandom_range(16, 800));
        end
        case ($urandom_range(0, 7))
            0: score = 17'($urandom_range(0, 131071));
            1, 2: score = 17'(40000 + 10000 * $urandom_range(0, 2));
            default: score = (cur_score_thr < 17'd65000) ?
                             17'($urandom_range(32'(cur_score_thr), 65536)) :
                             17'($urandom_range(0, 65536));
        endcase
        cls = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
        send_box(cx, cy, w, h, score, cls, last);
    endtask

    initial begin
        int                           sent, run_len, run_no;
        logic [pcbn_pkg::SCORE_W-1:0] thr_s[5] = '{17'd0, 17'd65536, 17'd0, 17'h1ffff, 17'd32768};
        logic [pcbn_pkg::SCORE_W-1:0] thr_o[5] = '{17'd0, 17'd65536, 17'd0, 17'h1ffff, 17'd20000};
        run_no = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed runs under reset thresholds
        send_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 17'd65536, 4'd0, 0);
        send_box(16'hffff, 16'hffff, 16'hffff, 16'hffff, 17'h1ffff, 4'd15, 0);
        send_box(16'd1000, 16'd1000, 16'd200, 16'd200, 17'd50000, 4'd3, 0);
        send_box(16'd1000, 16'd1000, 16'd200, 16'd200, 17'd50000, 4'd3, 0);
        send_box(16'd1010, 16'd1000, 16'd200, 16'd200, 17'd60000, 4'd3, 0);
        send_box(16'd5000, 16'd900, 16'd100, 16'd100, 17'd40000, 4'd3, 0);
        send_box(16'd5000, 16'd900, 16'd0, 16'd0, 17'd45000, 4'd7, 0);
        send_box(16'd5000, 16'd900, 16'd0, 16'd0, 17'd44000, 4'd7, 0);
        send_box(16'd2000, 16'd2000, 16'd50, 16'd50, 17'd32768, 4'd1, 0);
        send_box(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 17'h0aaaa, 4'd10, 1);
        send_box(16'd100, 16'd100, 16'd10, 16'd10, 17'd100, 4'd2, 1);
        send_box(16'd300, 16'd300, 16'd40, 16'd40, 17'd32769, 4'd5, 1);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = (ph % 4 == 1) ? 79 : (ph % 4 == 3) ? 20 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 79 : (ph % 4 == 3) ? 20 : 0;
            write_reg(pcbn_pkg::REG_SCORE_THR,
                      (ph == 2) ? 17'($urandom_range(0, 65536)) : thr_s[ph]);
            write_reg(pcbn_pkg::REG_OVL_THR,
                      (ph == 2) ? 17'($urandom_range(0, 65536)) : thr_o[ph]);
            if (ph == 4) begin
                write_reg(REG_SPARE_A, 17'd0);
                write_reg(REG_SPARE_B, 17'h1ffff);
            end
            cfg_valid <= 0;
            sent = 0;
            while (sent < ((ph == 3) ? 20 : 50)) begin
                run_len = (run_no == 2) ? 70 : $urandom_range(1, 9);
                cluster_x = 16'($urandom_range(0, 60000));
                cluster_y = 16'($urandom_range(0, 60000));
                for (int i = 0; i < run_len; i++)
                    random_box(i == run_len - 1);
                sent += run_len;
                run_no++;
            end
            drain();
        end

        if (fail_count == 0)
            $display("per_class_box_nms_unit verification clean");
        else
            $display("per_class_box_nms_unit verification failed");
        $finish;
    end
endmodule
